>>> hw/rtl/orf_pkg.sv
// Package for the open reading frame finder: beat types, register map and defaults.
package orf_pkg;

    localparam int QUEUE_DEPTH_DEF = 32;
    localparam int POS_WIDTH_DEF   = 32;

    localparam int ADDR_W = 5;
    localparam int DATA_W = 64;

    // Register indexes, taken from paddr[4:3].
    localparam logic [1:0] REG_START_MASK = 2'd0;
    localparam logic [1:0] REG_STOP_MASK  = 2'd1;
    localparam logic [1:0] REG_MIN_LENGTH = 2'd2;

    localparam logic [63:0] START_MASK_RST = 64'h0000_0000_0000_4000;
    localparam logic [63:0] STOP_MASK_RST  = 64'h0105_0000_0000_0000;
    localparam logic [9:0]  MIN_LENGTH_RST = 10'd0;

    typedef struct packed {
        logic [2:0] base_code;
        logic       new_sequence;
    } base_beat_t;

    typedef struct packed {
        logic [31:0] orf_first;
        logic [31:0] orf_last;
        logic        last_of_burst;
        logic        overflow_seen;
    } orf_beat_t;

    typedef struct packed {
        logic [63:0] start_mask;
        logic [63:0] stop_mask;
        logic [9:0]  min_length;
    } orf_cfg_t;

endpackage

>>> hw/rtl/orf_finder_stream.sv
// Top level of the open reading frame finder: codon tracking, start queues and drain.
//
//  channel  | direction | handshake           | payload
//  ---------+-----------+---------------------+---------------------------------
//  base     | in        | base_valid/stall    | base_beat: base_code, new_sequence
//  orf      | out       | orf_valid/stall     | orf_beat: first, last, burst end, overflow
//  apb      | in        | psel/penable/pready | paddr, pwdata, prdata (64 bits)
//
// A stop codon whose frame holds pending starts drains that queue from the start
// memory entry by entry, each through a read state and an evaluate state, then a
// final state for the last pair; base_stall is high all the while, and orf_stall
// can hold the drain back. The start memory has one write and one registered read
// port; reset clears the three fill counts, not the memory, so there is no clearing
// pass. A finished pair waits in the output register while the next base is taken.
module orf_finder_stream #(
    parameter int QUEUE_DEPTH = orf_pkg::QUEUE_DEPTH_DEF,
    parameter int POS_WIDTH   = orf_pkg::POS_WIDTH_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [orf_pkg::ADDR_W-1:0] paddr,
    input  logic [orf_pkg::DATA_W-1:0] pwdata,
    output logic [orf_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    input  logic                       base_valid,
    output logic                       base_stall,
    input  orf_pkg::base_beat_t        base_beat,
    output logic                       orf_valid,
    input  logic                       orf_stall,
    output orf_pkg::orf_beat_t         orf_beat
);
    import orf_pkg::*;

    localparam int CW    = $clog2(QUEUE_DEPTH + 1);
    localparam int IW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int DEPTH = 3 * QUEUE_DEPTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int SPW   = (POS_WIDTH > 12) ? POS_WIDTH : 12;
    // Frame of the first base of a codon at position 0, where p - 2 wraps.
    localparam logic [1:0] FM3_INIT =
        2'(((64'd1 << POS_WIDTH) - 64'd2) % 64'd3);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RD   = 2'd1;
    localparam logic [1:0] ST_EV   = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    orf_cfg_t cfg;

    orf_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    logic [1:0]           state_reg, state_next;
    logic [POS_WIDTH-1:0] pos_reg, pos_next;
    logic [1:0]           fm3_reg, fm3_next;
    logic [3:0]           prior_reg, prior_next;
    logic [1:0]           seen_reg, seen_next;
    logic [CW-1:0]        cnt_reg [3];
    logic [CW-1:0]        cnt_next [3];
    logic                 ovf_reg, ovf_next;
    logic [1:0]           frame_reg, frame_next;
    logic [IW-1:0]        k_reg, k_next;
    logic [IW-1:0]        n_last_reg, n_last_next;
    logic                 hold_valid_reg, hold_valid_next;
    orf_beat_t            hold_reg, hold_next;
    logic                 out_valid_reg, out_valid_next;
    orf_beat_t            out_reg, out_next;

    logic [POS_WIDTH-1:0] mem [DEPTH];
    logic [POS_WIDTH-1:0] rdata_reg;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [POS_WIDTH-1:0] wr_data;
    logic                 rd_en;
    logic [AW-1:0]        rd_addr;

    logic                 accept;
    logic                 out_free;
    logic [POS_WIDTH-1:0] p_cur;
    logic [1:0]           fm3_cur;
    logic [5:0]           codon;
    logic                 have_codon;
    logic                 start_hit;
    logic                 stop_hit;
    logic [CW-1:0]        cnt_sel;
    logic [POS_WIDTH-1:0] span;
    logic [11:0]          threshold;
    logic                 pass;

    assign accept     = base_valid && !base_stall;
    assign base_stall = (state_reg != ST_IDLE);
    assign out_free   = !out_valid_reg || !orf_stall;
    assign orf_valid  = out_valid_reg;
    assign orf_beat   = out_reg;

    // A new sequence restarts the position before this base is counted.
    assign p_cur   = base_beat.new_sequence ? '0 : pos_reg;
    assign fm3_cur = base_beat.new_sequence ? FM3_INIT : fm3_reg;
    assign codon   = {prior_reg, base_beat.base_code[1:0]};
    assign have_codon = !base_beat.base_code[2] && !base_beat.new_sequence
                        && (seen_reg == 2'd2);
    assign start_hit  = have_codon && cfg.start_mask[codon];
    assign stop_hit   = have_codon && cfg.stop_mask[codon];
    assign cnt_sel    = cnt_reg[fm3_cur];

    // pos_reg already holds the stop's position plus one during a drain.
    assign span      = pos_reg - rdata_reg - POS_WIDTH'(1);
    assign threshold = 12'({2'd0, cfg.min_length} * 12'd3) + 12'd5;
    assign pass      = SPW'(span) >= SPW'(threshold);

    assign wr_en   = accept && start_hit && (cnt_sel < CW'(QUEUE_DEPTH));
    assign wr_addr = AW'(32'(fm3_cur) * QUEUE_DEPTH + 32'(cnt_sel[IW-1:0]));
    assign wr_data = p_cur - POS_WIDTH'(2);
    assign rd_en   = (state_reg == ST_RD);
    assign rd_addr = AW'(32'(frame_reg) * QUEUE_DEPTH + 32'(k_reg));

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        pos_next        = pos_reg;
        fm3_next        = fm3_reg;
        prior_next      = prior_reg;
        seen_next       = seen_reg;
        cnt_next        = cnt_reg;
        ovf_next        = ovf_reg;
        frame_next      = frame_reg;
        k_next          = k_reg;
        n_last_next     = n_last_reg;
        hold_valid_next = hold_valid_reg;
        hold_next       = hold_reg;
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;

        if (out_valid_reg && !orf_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (base_beat.new_sequence)
                    begin
                        prior_next = '0;
                        seen_next  = '0;
                        ovf_next   = 1'b0;
                        for (int f = 0; f < 3; f++)
                        begin
                            cnt_next[f] = '0;
                        end
                    end
                    pos_next = p_cur + POS_WIDTH'(1);
                    fm3_next = (p_cur == POS_WIDTH'(1)) ? 2'd0 :
                               (fm3_cur == 2'd2) ? 2'd0 : fm3_cur + 2'd1;
                    if (base_beat.base_code[2])
                    begin
                        prior_next = '0;
                        seen_next  = '0;
                    end
                    else
                    begin
                        prior_next = {(base_beat.new_sequence ? 2'd0 : prior_reg[1:0]),
                                      base_beat.base_code[1:0]};
                        seen_next  = base_beat.new_sequence ? 2'd1 :
                                     (seen_reg == 2'd2) ? 2'd2 : seen_reg + 2'd1;
                    end
                    if (start_hit)
                    begin
                        if (cnt_sel < CW'(QUEUE_DEPTH))
                        begin
                            cnt_next[fm3_cur] = cnt_sel + CW'(1);
                        end
                        else
                        begin
                            ovf_next = 1'b1;
                        end
                    end
                    // The stop drains only the starts queued before this codon;
                    // a start in the same codon has a span of two and never passes.
                    if (stop_hit)
                    begin
                        cnt_next[fm3_cur] = '0;
                        if (cnt_sel != '0)
                        begin
                            frame_next  = fm3_cur;
                            k_next      = '0;
                            n_last_next = IW'(cnt_sel - CW'(1));
                            state_next  = ST_RD;
                        end
                    end
                end
            end
            ST_RD:
            begin
                state_next = ST_EV;
            end
            ST_EV:
            begin
                if (!(pass && hold_valid_reg && !out_free))
                begin
                    if (pass)
                    begin
                        if (hold_valid_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_next       = hold_reg;
                        end
                        hold_valid_next         = 1'b1;
                        hold_next.orf_first     = 32'(rdata_reg + POS_WIDTH'(1));
                        hold_next.orf_last      = 32'(pos_reg);
                        hold_next.last_of_burst = 1'b0;
                        hold_next.overflow_seen = ovf_reg;
                    end
                    k_next     = k_reg + IW'(1);
                    state_next = (k_reg == n_last_reg) ? ST_FIN : ST_RD;
                end
            end
            ST_FIN:
            begin
                if (!hold_valid_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    out_valid_next         = 1'b1;
                    out_next               = hold_reg;
                    out_next.last_of_burst = 1'b1;
                    hold_valid_next        = 1'b0;
                    state_next             = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            pos_reg        <= '0;
            fm3_reg        <= FM3_INIT;
            prior_reg      <= '0;
            seen_reg       <= '0;
            ovf_reg        <= 1'b0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            for (int f = 0; f < 3; f++)
            begin
                cnt_reg[f] <= '0;
            end
        end
        else
        begin
            state_reg      <= state_next;
            pos_reg        <= pos_next;
            fm3_reg        <= fm3_next;
            prior_reg      <= prior_next;
            seen_reg       <= seen_next;
            ovf_reg        <= ovf_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
            cnt_reg        <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        frame_reg  <= frame_next;
        k_reg      <= k_next;
        n_last_reg <= n_last_next;
        hold_reg   <= hold_next;
        out_reg    <= out_next;
    end

    // A pair is only ever held back while a queue is being drained.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !hold_valid_reg)
        else $error("held pair left behind after a drain");

    // The drain never reads past the entries that the stop found queued.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RD) |-> (k_reg <= n_last_reg))
        else $error("drain index beyond queue fill");

    // No fill count exceeds the queue depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg[0] <= CW'(QUEUE_DEPTH)) && (cnt_reg[1] <= CW'(QUEUE_DEPTH))
        && (cnt_reg[2] <= CW'(QUEUE_DEPTH)))
        else $error("queue fill count overrun");

    // A stop that finds pending starts always starts a drain.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && stop_hit && (cnt_sel != '0)) |=> (state_reg == ST_RD))
        else $error("stop with pending starts did not drain");

endmodule

>>> hw/rtl/orf_cfg_regs.sv
// Configuration register file behind the APB-style port.
module orf_cfg_regs (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [orf_pkg::ADDR_W-1:0] paddr,
    input  logic [orf_pkg::DATA_W-1:0] pwdata,
    output logic [orf_pkg::DATA_W-1:0] prdata,
    output logic                      pready,
    output orf_pkg::orf_cfg_t         cfg
);
    import orf_pkg::*;

    orf_cfg_t   cfg_reg;
    logic [1:0] reg_index;
    logic       wr_en;

    assign reg_index = paddr[4:3];
    assign wr_en     = psel && penable && pwrite;
    assign pready    = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_mask <= START_MASK_RST;
            cfg_reg.stop_mask  <= STOP_MASK_RST;
            cfg_reg.min_length <= MIN_LENGTH_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_index)
                REG_START_MASK: cfg_reg.start_mask <= pwdata;
                REG_STOP_MASK:  cfg_reg.stop_mask  <= pwdata;
                REG_MIN_LENGTH: cfg_reg.min_length <= pwdata[9:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_index)
            REG_START_MASK: prdata = cfg_reg.start_mask;
            REG_STOP_MASK:  prdata = cfg_reg.stop_mask;
            REG_MIN_LENGTH: prdata = {54'd0, cfg_reg.min_length};
            default:        prdata = '0;
        endcase
    end

endmodule

>>> tb/orf_finder_stream_test.sv
// Self-checking testbench for the streaming open reading frame finder.
`timescale 1ns / 100ps

module orf_finder_stream_test;
    import orf_pkg::*;

    localparam int QDEPTH        = QUEUE_DEPTH_DEF;
    localparam int QUIET_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 100;

    localparam logic [2:0] BASE_A      = 3'd0;
    localparam logic [2:0] BASE_G      = 3'd2;
    localparam logic [2:0] BASE_T      = 3'd3;
    localparam logic [2:0] BASE_N      = 3'd4;
    localparam logic [2:0] BASE_N_LAST = 3'd7;

    localparam logic [5:0] CODON_ATG = 6'd14;
    localparam logic [5:0] CODON_TAA = 6'd48;
    localparam logic [5:0] CODON_TAG = 6'd50;
    localparam logic [5:0] CODON_TTT = 6'd63;

    localparam logic [63:0] ALL_CODONS = '1;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [ADDR_W-1:0]  paddr;
    logic [DATA_W-1:0]  pwdata;
    logic [DATA_W-1:0]  prdata;
    logic               pready;
    logic               base_valid;
    logic               base_stall;
    base_beat_t         base_beat;
    logic               orf_valid;
    logic               orf_stall;
    orf_beat_t          orf_beat;

    int idle_pct   = 0;
    int stall_pct  = 0;
    int fail_count = 0;

    // Mirror of the block's registers and per-sequence state.
    logic [63:0] start_set;
    logic [63:0] stop_set;
    logic [9:0]  min_codons;
    logic [31:0] seq_pos;
    logic [3:0]  last_two;
    logic [1:0]  run_len;
    logic [31:0] frame_starts [3][QDEPTH];
    int          frame_fill [3];
    logic        dropped_start;

    orf_beat_t   orfs_due [$];

    orf_finder_stream DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .base_valid (base_valid),
        .base_stall (base_stall),
        .base_beat  (base_beat),
        .orf_valid  (orf_valid),
        .orf_stall  (orf_stall),
        .orf_beat   (orf_beat)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        orf_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            orf_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    function automatic void restart_sequence();
        seq_pos       = '0;
        last_two      = '0;
        run_len       = '0;
        frame_fill    = '{0, 0, 0};
        dropped_start = 1'b0;
    endfunction

    // Works out the pairs that one accepted base beat releases.
    function automatic void scan_base(base_beat_t b);
        logic [31:0] p;
        logic [31:0] first;
        logic [31:0] span;
        logic [31:0] threshold;
        logic [5:0]  codon;
        int          frame;
        int          n_pass;
        bit          have_codon;
        orf_beat_t   pair;
        if (b.new_sequence)
            restart_sequence();
        p = seq_pos;
        seq_pos = p + 32'd1;
        if (b.base_code > BASE_T)
        begin
            run_len = '0;
            last_two = '0;
            return;
        end
        have_codon = (run_len >= 2'd2);
        codon = {last_two, b.base_code[1:0]};
        last_two = {last_two[1:0], b.base_code[1:0]};
        if (run_len < 2'd2)
            run_len = run_len + 2'd1;
        if (!have_codon)
            return;
        first = p - 32'd2;
        frame = int'(first % 32'd3);
        // The start goes in first, so a codon in both sets pops itself.
        if (start_set[codon])
        begin
            if (frame_fill[frame] < QDEPTH)
            begin
                frame_starts[frame][frame_fill[frame]] = first;
                frame_fill[frame]++;
            end
            else
                dropped_start = 1'b1;
        end
        if (stop_set[codon])
        begin
            threshold = 32'd3 * 32'(min_codons) + 32'd5;
            n_pass = 0;
            for (int k = 0; k < frame_fill[frame]; k++)
            begin
                span = p - frame_starts[frame][k];
                if (span >= threshold)
                begin
                    pair.orf_first     = frame_starts[frame][k] + 32'd1;
                    pair.orf_last      = p + 32'd1;
                    pair.last_of_burst = 1'b0;
                    pair.overflow_seen = dropped_start;
                    orfs_due.push_back(pair);
                    n_pass++;
                end
            end
            frame_fill[frame] = 0;
            if (n_pass > 0)
                orfs_due[orfs_due.size() - 1].last_of_burst = 1'b1;
        end
    endfunction

    always @(posedge clk)
    begin : orf_check
        orf_beat_t want;
        if (orf_valid && !orf_stall)
        begin
            if (orfs_due.size() == 0)
            begin
                $error("orf beat %0d..%0d arrived with none due",
                       orf_beat.orf_first, orf_beat.orf_last);
                fail_count++;
            end
            else
            begin
                want = orfs_due.pop_front();
                if (orf_beat.orf_first !== want.orf_first)
                begin
                    $error("orf_first: expected %0d, got %0d",
                           want.orf_first, orf_beat.orf_first);
                    fail_count++;
                end
                if (orf_beat.orf_last !== want.orf_last)
                begin
                    $error("orf_last: expected %0d, got %0d",
                           want.orf_last, orf_beat.orf_last);
                    fail_count++;
                end
                if (orf_beat.last_of_burst !== want.last_of_burst)
                begin
                    $error("last_of_burst: expected %0b, got %0b",
                           want.last_of_burst, orf_beat.last_of_burst);
                    fail_count++;
                end
                if (orf_beat.overflow_seen !== want.overflow_seen)
                begin
                    $error("overflow_seen: expected %0b, got %0b",
                           want.overflow_seen, orf_beat.overflow_seen);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((base_valid && !base_stall) || (orf_valid && !orf_stall))
                quiet = 0;
            else
                quiet++;
        end
        $error("no beat moved for %0d cycles", QUIET_LIMIT);
        $display("orf_finder_stream_test: done, errors");
        $finish;
    end

    task automatic send_base(input logic [2:0] code, input logic fresh);
        base_beat_t b;
        b.base_code    = code;
        b.new_sequence = fresh;
        @(negedge clk);
        while ($urandom_range(99) < idle_pct)
        begin
            base_valid <= 1'b0;
            @(negedge clk);
        end
        base_valid <= 1'b1;
        base_beat  <= b;
        do
            @(posedge clk);
        while (base_stall);
        scan_base(b);
    endtask

    task automatic send_codon(input logic [5:0] codon, input logic fresh);
        send_base({1'b0, codon[5:4]}, fresh);
        send_base({1'b0, codon[3:2]}, 1'b0);
        send_base({1'b0, codon[1:0]}, 1'b0);
    endtask

    function automatic logic [5:0] pick_codon(logic [63:0] codon_set);
        logic [5:0] c;
        c = 6'($urandom_range(63));
        for (int t = 0; t < 256 && codon_set != '0; t++)
        begin
            if (codon_set[c])
                return c;
            c = 6'($urandom_range(63));
        end
        return c;
    endfunction

    // Mostly random bases, with codons from the current sets, fresh sequences and odd letters mixed in.
    task automatic send_mixed(input int n);
        int sent;
        int roll;
        sent = 0;
        while (sent < n)
        begin
            roll = $urandom_range(99);
            if (roll < 8)
            begin
                send_base(3'($urandom_range(BASE_T, BASE_A)), 1'b1);
                sent++;
            end
            else if (roll < 23)
            begin
                send_codon(pick_codon(start_set), 1'b0);
                sent += 3;
            end
            else if (roll < 33)
            begin
                send_codon(pick_codon(stop_set), 1'b0);
                sent += 3;
            end
            else if (roll < 38)
            begin
                send_base(3'($urandom_range(BASE_N_LAST, BASE_N)), 1'b0);
                sent++;
            end
            else
            begin
                send_base(3'($urandom_range(BASE_T, BASE_A)), 1'b0);
                sent++;
            end
        end
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [63:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 3'b000};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (index)
            REG_START_MASK: start_set  = value;
            REG_STOP_MASK:  stop_set   = value;
            REG_MIN_LENGTH: min_codons = value[9:0];
            default: ;
        endcase
    endtask

    task automatic configure(input logic [63:0] starts, input logic [63:0] stops,
                             input logic [63:0] min_word);
        write_reg(REG_START_MASK, starts);
        write_reg(REG_STOP_MASK, stops);
        write_reg(REG_MIN_LENGTH, min_word);
    endtask

    task automatic drain_orfs();
        @(negedge clk);
        base_valid <= 1'b0;
        while (orfs_due.size() != 0)
            @(posedge clk);
    endtask

    // A stop that releases nothing may still be draining its queue, so allow for it.
    task automatic settle();
        drain_orfs();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic test_default_codons();
        // Two starts in frame 0 closed by one stop, then a start closed by a second stop.
        send_codon(CODON_ATG, 1'b1);
        send_codon(CODON_ATG, 1'b0);
        send_codon(CODON_TAA, 1'b0);
        send_codon(CODON_ATG, 1'b0);
        send_codon(CODON_TAG, 1'b0);
        // An odd letter inside a would-be stop breaks the codon history.
        send_base(BASE_T, 1'b0);
        send_base(BASE_A, 1'b0);
        send_base(BASE_N_LAST, 1'b0);
        send_base(BASE_A, 1'b0);
        settle();
    endtask

    task automatic test_shared_codon();
        configure((64'd1 << CODON_ATG) | (64'd1 << CODON_TAA), STOP_MASK_RST, 64'd1);
        send_codon(CODON_ATG, 1'b1);
        send_codon(CODON_TAA, 1'b0);
        settle();
    endtask

    task automatic test_quiet_stream();
        idle_pct  = 0;
        stall_pct = 0;
        configure(START_MASK_RST, STOP_MASK_RST, 64'd0);
        send_mixed(35);
        settle();
    endtask

    task automatic test_sender_gaps();
        idle_pct  = 50;
        stall_pct = 0;
        configure({$urandom, $urandom}, {$urandom, $urandom},
                  {$urandom, 22'($urandom), 10'($urandom_range(3))});
        send_mixed(18);
        // Hold the sender back until every pair so far has come out.
        drain_orfs();
        send_mixed(17);
        settle();
    endtask

    task automatic test_full_queues();
        idle_pct  = 0;
        stall_pct = 50;
        configure(ALL_CODONS, 64'd1 << CODON_TTT, 64'd0);
        send_base(BASE_A, 1'b1);
        repeat (99) send_base(3'($urandom_range(BASE_G, BASE_A)), 1'b0);
        // Five T bases give a TTT stop in each frame, each draining a full queue.
        repeat (5) send_base(BASE_T, 1'b0);
        settle();
    endtask

    task automatic test_both_idle();
        idle_pct  = 9;
        stall_pct = 9;
        configure({$urandom, $urandom}, {$urandom, $urandom}, 64'd0);
        send_mixed(25);
        settle();
    endtask

    task automatic test_extremes();
        idle_pct  = 9;
        stall_pct = 9;
        configure(ALL_CODONS, ALL_CODONS, 64'd1023);
        send_mixed(6);
        settle();
        configure(64'd0, ALL_CODONS, 64'd0);
        send_mixed(6);
        settle();
    endtask

    initial
    begin
        rst_n      = 1'b0;
        base_valid = 1'b0;
        base_beat  = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        start_set  = START_MASK_RST;
        stop_set   = STOP_MASK_RST;
        min_codons = MIN_LENGTH_RST;
        restart_sequence();
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        test_default_codons();
        test_shared_codon();
        test_quiet_stream();
        test_sender_gaps();
        test_full_queues();
        test_both_idle();
        test_extremes();

        if (fail_count == 0)
            $display("orf_finder_stream_test: done, clean");
        else
            $display("orf_finder_stream_test: done, errors");
        $finish;
    end

endmodule
